>>> design/qpr_pkg.sv
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared types and constants for the quaternion point rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package qpr_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_Q = 30;               // Q2.30 quaternion fraction bits
  localparam int PROD_W = 2 * WORD_W - FRAC_Q; // product after >>> FRAC_Q
  localparam int AXES   = 3;
  localparam int QPARTS = 4;
  localparam int REG_IDX_W = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t ROT_W_RESET = 32'sh4000_0000;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ROT_W   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROT_X   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROT_Y   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROT_Z   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PIVOT_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PIVOT_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PIVOT_Z = 3'd6;

  // quaternion part positions
  localparam int QW = 0;
  localparam int QX = 1;
  localparam int QY = 2;
  localparam int QZ = 3;

endpackage

`default_nettype wire

>>> design/qpr_addsat.sv
// ----------------------------------------------------------------------------
// qpr_addsat
// Three-lane registered add or subtract with 32-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module qpr_addsat (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic          sub,
  input  wire qpr_pkg::word_t a [qpr_pkg::AXES],
  input  wire qpr_pkg::word_t b [qpr_pkg::AXES],
  output qpr_pkg::word_t      y [qpr_pkg::AXES]
);
  import qpr_pkg::*;

  logic signed [WORD_W:0] sum [AXES];
  word_t                  y_next [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (sub) begin
        sum[i] = (WORD_W + 1)'(a[i]) - (WORD_W + 1)'(b[i]);
      end else begin
        sum[i] = (WORD_W + 1)'(a[i]) + (WORD_W + 1)'(b[i]);
      end
      // top two bits differ only on overflow
      if (sum[i][WORD_W] == sum[i][WORD_W-1]) begin
        y_next[i] = sum[i][WORD_W-1:0];
      end else if (sum[i][WORD_W]) begin
        y_next[i] = WORD_MIN;
      end else begin
        y_next[i] = WORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      y <= y_next;
    end
  end

endmodule

`default_nettype wire

>>> design/qpr_mul_bank.sv
// ----------------------------------------------------------------------------
// qpr_mul_bank
// Bank of registered 32x32 signed multipliers, each result floored by 2^30.
// ----------------------------------------------------------------------------
`default_nettype none

module qpr_mul_bank #(
  parameter int N = 12
) (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire qpr_pkg::word_t a [N],
  input  wire qpr_pkg::word_t b [N],
  output qpr_pkg::prod_t      p [N]
);
  import qpr_pkg::*;

  logic signed [2*WORD_W-1:0] full [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      full[i] = a[i] * b[i];
    end
  end

  // arithmetic shift right: keep the upper bits, which floors
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < N; i++) begin
        p[i] <= full[i][FRAC_Q +: PROD_W];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/qpr_combine.sv
// ----------------------------------------------------------------------------
// qpr_combine
// Signed sums of scaled products, one per output lane, saturated and
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module qpr_combine #(
  parameter int N_OUT  = 4,
  parameter int N_TERM = 3
) (
  input  wire logic                           clk,
  input  wire logic                           load,
  input  wire logic [N_OUT-1:0][N_TERM-1:0]   neg,
  input  wire qpr_pkg::prod_t                 term [N_OUT][N_TERM],
  output qpr_pkg::word_t                      sum  [N_OUT]
);
  import qpr_pkg::*;

  localparam int AW = PROD_W + $clog2(N_TERM) + 1;

  logic signed [AW-1:0] acc      [N_OUT];
  word_t                sum_next [N_OUT];

  always_comb begin
    for (int o = 0; o < N_OUT; o++) begin
      acc[o] = '0;
      for (int t = 0; t < N_TERM; t++) begin
        if (neg[o][t]) begin
          acc[o] = acc[o] - AW'(term[o][t]);
        end else begin
          acc[o] = acc[o] + AW'(term[o][t]);
        end
      end
      if (acc[o][AW-1:WORD_W-1] == '0 || acc[o][AW-1:WORD_W-1] == '1) begin
        sum_next[o] = acc[o][WORD_W-1:0];
      end else if (acc[o][AW-1]) begin
        sum_next[o] = WORD_MIN;
      end else begin
        sum_next[o] = WORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

>>> design/quaternion_point_rotator.sv
// ----------------------------------------------------------------------------
// quaternion_point_rotator
// Rotates a Q16.16 point about a pivot by the quaternion r: vector part of
// r * (0, p - pivot) * conj(r), plus the pivot.
// ----------------------------------------------------------------------------
//
//   channel   signals                                  direction
//   point     point_valid, point_stall, point_x/y/z    request in
//   rotated   rotated_valid, rotated_stall, rotated_*  request out
//   config    wr_en, wr_index, wr_data                 register write in
//
// Six register stages: offset, product, sum, product, sum, pivot add.
// One request per cycle while the output is not stalled.
// Each stage holds its request until the next one frees, so a stall at the
// output fills the stages from the back and only then raises point_stall.
// Synchronous reset empties the pipeline and restores r to one, pivot to 0.
`default_nettype none

module quaternion_point_rotator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                point_valid,
  output logic                                     point_stall,
  input  wire qpr_pkg::word_t                      point_x,
  input  wire qpr_pkg::word_t                      point_y,
  input  wire qpr_pkg::word_t                      point_z,
  output logic                                     rotated_valid,
  input  wire logic                                rotated_stall,
  output qpr_pkg::word_t                           rotated_x,
  output qpr_pkg::word_t                           rotated_y,
  output qpr_pkg::word_t                           rotated_z,
  input  wire logic                                wr_en,
  input  wire logic [qpr_pkg::REG_IDX_W-1:0]       wr_index,
  input  wire qpr_pkg::word_t                      wr_data
);
  import qpr_pkg::*;

  localparam int STAGES = 6;
  localparam int N1 = QPARTS * AXES;   // first product: 4 sums of 3
  localparam int N2 = AXES * QPARTS;   // second product: 3 sums of 4

  // term signs, bit t of group o set means subtract
  localparam logic [QPARTS-1:0][AXES-1:0] NEG1 = {3'b100, 3'b010, 3'b100, 3'b111};
  localparam logic [AXES-1:0][QPARTS-1:0] NEG2 = {4'b0011, 4'b1001, 4'b0101};

  word_t rot   [QPARTS];
  word_t pivot [AXES];

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rdy;
  logic [STAGES-1:0] load;

  word_t point [AXES];
  word_t v     [AXES];
  word_t m1_a  [N1];
  word_t m1_b  [N1];
  prod_t m1_p  [N1];
  prod_t c1_in [QPARTS][AXES];
  word_t t     [QPARTS];
  word_t m2_a  [N2];
  word_t m2_b  [N2];
  prod_t m2_p  [N2];
  prod_t c2_in [AXES][QPARTS];
  word_t o     [AXES];
  word_t res   [AXES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rot[QW]  <= ROT_W_RESET;
      rot[QX]  <= '0;
      rot[QY]  <= '0;
      rot[QZ]  <= '0;
      pivot[0] <= '0;
      pivot[1] <= '0;
      pivot[2] <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROT_W:   rot[QW]  <= wr_data;
        REG_ROT_X:   rot[QX]  <= wr_data;
        REG_ROT_Y:   rot[QY]  <= wr_data;
        REG_ROT_Z:   rot[QZ]  <= wr_data;
        REG_PIVOT_X: pivot[0] <= wr_data;
        REG_PIVOT_Y: pivot[1] <= wr_data;
        REG_PIVOT_Z: pivot[2] <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // stage handshake: a stage takes a new request when empty or draining
  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || !rotated_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    load[0] = rdy[0] && point_valid;
    for (int i = 1; i < STAGES; i++) begin
      load[i] = rdy[i] && vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= point_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign point_stall   = !rdy[0];
  assign rotated_valid = vld[STAGES-1];

  assign point[0] = point_x;
  assign point[1] = point_y;
  assign point[2] = point_z;

  qpr_addsat u_offset (
    .clk  (clk),
    .load (load[0]),
    .sub  (1'b1),
    .a    (point),
    .b    (pivot),
    .y    (v)
  );

  // t = r * (0, v); lane = part * 3 + term
  always_comb begin
    m1_a[0]  = rot[QX]; m1_b[0]  = v[0];
    m1_a[1]  = rot[QY]; m1_b[1]  = v[1];
    m1_a[2]  = rot[QZ]; m1_b[2]  = v[2];
    m1_a[3]  = rot[QW]; m1_b[3]  = v[0];
    m1_a[4]  = rot[QY]; m1_b[4]  = v[2];
    m1_a[5]  = rot[QZ]; m1_b[5]  = v[1];
    m1_a[6]  = rot[QW]; m1_b[6]  = v[1];
    m1_a[7]  = rot[QX]; m1_b[7]  = v[2];
    m1_a[8]  = rot[QZ]; m1_b[8]  = v[0];
    m1_a[9]  = rot[QW]; m1_b[9]  = v[2];
    m1_a[10] = rot[QX]; m1_b[10] = v[1];
    m1_a[11] = rot[QY]; m1_b[11] = v[0];
  end

  qpr_mul_bank #(.N(N1)) u_mul1 (
    .clk  (clk),
    .load (load[1]),
    .a    (m1_a),
    .b    (m1_b),
    .p    (m1_p)
  );

  always_comb begin
    for (int g = 0; g < QPARTS; g++) begin
      for (int k = 0; k < AXES; k++) begin
        c1_in[g][k] = m1_p[g*AXES + k];
      end
    end
  end

  qpr_combine #(.N_OUT(QPARTS), .N_TERM(AXES)) u_sum1 (
    .clk  (clk),
    .load (load[2]),
    .neg  (NEG1),
    .term (c1_in),
    .sum  (t)
  );

  // vector part of t * conj(r); lane = axis * 4 + term
  always_comb begin
    m2_a[0]  = t[QW]; m2_b[0]  = rot[QX];
    m2_a[1]  = t[QX]; m2_b[1]  = rot[QW];
    m2_a[2]  = t[QY]; m2_b[2]  = rot[QZ];
    m2_a[3]  = t[QZ]; m2_b[3]  = rot[QY];
    m2_a[4]  = t[QW]; m2_b[4]  = rot[QY];
    m2_a[5]  = t[QX]; m2_b[5]  = rot[QZ];
    m2_a[6]  = t[QY]; m2_b[6]  = rot[QW];
    m2_a[7]  = t[QZ]; m2_b[7]  = rot[QX];
    m2_a[8]  = t[QW]; m2_b[8]  = rot[QZ];
    m2_a[9]  = t[QX]; m2_b[9]  = rot[QY];
    m2_a[10] = t[QY]; m2_b[10] = rot[QX];
    m2_a[11] = t[QZ]; m2_b[11] = rot[QW];
  end

  qpr_mul_bank #(.N(N2)) u_mul2 (
    .clk  (clk),
    .load (load[3]),
    .a    (m2_a),
    .b    (m2_b),
    .p    (m2_p)
  );

  always_comb begin
    for (int g = 0; g < AXES; g++) begin
      for (int k = 0; k < QPARTS; k++) begin
        c2_in[g][k] = m2_p[g*QPARTS + k];
      end
    end
  end

  qpr_combine #(.N_OUT(AXES), .N_TERM(QPARTS)) u_sum2 (
    .clk  (clk),
    .load (load[4]),
    .neg  (NEG2),
    .term (c2_in),
    .sum  (o)
  );

  qpr_addsat u_restore (
    .clk  (clk),
    .load (load[5]),
    .sub  (1'b0),
    .a    (o),
    .b    (pivot),
    .y    (res)
  );

  assign rotated_x = res[0];
  assign rotated_y = res[1];
  assign rotated_z = res[2];

  // input backs up only when every stage holds a request
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    point_stall |-> (&vld))
    else $error("point_stall with an empty stage");

  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !rotated_stall |-> !point_stall)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("pipeline not empty after reset");

  a_hold_blocked: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && !rdy[0]) |=> vld[0])
    else $error("blocked request dropped from first stage");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams Q16.16 points through quaternion_point_rotator under several
// rotation and pivot settings, with random request gaps and output stalls,
// and checks each rotated point against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import qpr_pkg::*;

  localparam int DRAIN_CYCLES = 16;          // pipeline is six stages deep
  localparam int TIMEOUT      = 5_000_000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_POINTS  = 75;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vec3_t;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_stall;
  word_t point_x = '0;
  word_t point_y = '0;
  word_t point_z = '0;
  logic rotated_valid;
  logic rotated_stall = 1'b0;
  word_t rotated_x;
  word_t rotated_y;
  word_t rotated_z;
  logic wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  word_t wr_data = '0;

  quaternion_point_rotator uut (
    .clk(clk),
    .rst(rst),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .rotated_valid(rotated_valid),
    .rotated_stall(rotated_stall),
    .rotated_x(rotated_x),
    .rotated_y(rotated_y),
    .rotated_z(rotated_z),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  // register copy used by the predictor
  word_t cfg_w = ROT_W_RESET;
  word_t cfg_x = '0;
  word_t cfg_y = '0;
  word_t cfg_z = '0;
  word_t cfg_px = '0;
  word_t cfg_py = '0;
  word_t cfg_pz = '0;

  vec3_t point_q[$];
  vec3_t rotated_q[$];
  int mismatches = 0;

  function automatic longint clamp_word(longint v);
    if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
    if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
    return v;
  endfunction

  // floor(a*b / 2^30)
  function automatic longint mul_q30(longint a, longint b);
    return (a * b) >>> FRAC_Q;
  endfunction

  function automatic vec3_t rotate_point(vec3_t p);
    longint w, x, y, z, px, py, pz, vx, vy, vz;
    longint tw, tx, ty, tz, ox, oy, oz;
    vec3_t r;
    w  = longint'(cfg_w);
    x  = longint'(cfg_x);
    y  = longint'(cfg_y);
    z  = longint'(cfg_z);
    px = longint'(cfg_px);
    py = longint'(cfg_py);
    pz = longint'(cfg_pz);
    vx = clamp_word(longint'($signed(p.x)) - px);
    vy = clamp_word(longint'($signed(p.y)) - py);
    vz = clamp_word(longint'($signed(p.z)) - pz);
    // t = r * (0, v)
    tw = clamp_word(-mul_q30(x, vx) - mul_q30(y, vy) - mul_q30(z, vz));
    tx = clamp_word(mul_q30(w, vx) + mul_q30(y, vz) - mul_q30(z, vy));
    ty = clamp_word(mul_q30(w, vy) - mul_q30(x, vz) + mul_q30(z, vx));
    tz = clamp_word(mul_q30(w, vz) + mul_q30(x, vy) - mul_q30(y, vx));
    // vector part of t * conj(r); conjugate sign folded into each term
    ox = clamp_word(-mul_q30(tw, x) + mul_q30(tx, w) - mul_q30(ty, z) + mul_q30(tz, y));
    oy = clamp_word(-mul_q30(tw, y) + mul_q30(tx, z) + mul_q30(ty, w) - mul_q30(tz, x));
    oz = clamp_word(-mul_q30(tw, z) - mul_q30(tx, y) + mul_q30(ty, x) + mul_q30(tz, w));
    r.x = word_t'(clamp_word(ox + px));
    r.y = word_t'(clamp_word(oy + py));
    r.z = word_t'(clamp_word(oz + pz));
    return r;
  endfunction

  // ---------------- request driver: bursts with random gaps ----------------
  vec3_t drv_point;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (!point_valid || !point_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        point_valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        drv_point = point_q.pop_front();
        point_x <= drv_point.x;
        point_y <= drv_point.y;
        point_z <= drv_point.z;
        point_valid <= 1'b1;
        rotated_q.push_back(rotate_point(drv_point));
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        point_valid <= 1'b0;
      end
    end
  end

  // ---------------- output stall pattern ----------------
  stall_mode_t stall_mode = STALL_NONE;
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      rotated_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(8, 60);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_NONE:  rotated_stall <= 1'b0;
        STALL_HALF:  rotated_stall <= ($urandom_range(0, 1) == 1);
        STALL_LIGHT: rotated_stall <= ($urandom_range(0, 7) == 0);
        default:     rotated_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------- result monitor ----------------
  vec3_t want;

  task automatic check_field(input string name, input word_t exp_v, input word_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d (0x%08h) got %0d (0x%08h)",
               $time, name, exp_v, exp_v, act_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rotated_valid && !rotated_stall) begin
      if (rotated_q.size() == 0) begin
        $display("%0t: rotated point with no request pending: %0d %0d %0d",
                 $time, rotated_x, rotated_y, rotated_z);
        mismatches++;
      end else begin
        want = rotated_q.pop_front();
        check_field("rotated_x", want.x, rotated_x);
        check_field("rotated_y", want.y, rotated_y);
        check_field("rotated_z", want.z, rotated_z);
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic wait_idle();
    while (point_q.size() != 0 || point_valid || rotated_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input word_t val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_ROT_W:   cfg_w = val;
      REG_ROT_X:   cfg_x = val;
      REG_ROT_Y:   cfg_y = val;
      REG_ROT_Z:   cfg_z = val;
      REG_PIVOT_X: cfg_px = val;
      REG_PIVOT_Y: cfg_py = val;
      REG_PIVOT_Z: cfg_pz = val;
      default: ;   // unmapped index: block must ignore it
    endcase
  endtask

  task automatic reconfigure(input word_t w, input word_t x, input word_t y, input word_t z,
                             input word_t px, input word_t py, input word_t pz);
    wait_idle();
    write_reg(REG_ROT_W, w);
    write_reg(REG_ROT_X, x);
    write_reg(REG_UNUSED, word_t'($urandom));
    write_reg(REG_ROT_Y, y);
    write_reg(REG_ROT_Z, z);
    write_reg(REG_PIVOT_X, px);
    write_reg(REG_PIVOT_Y, py);
    write_reg(REG_PIVOT_Z, pz);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic add_point(input word_t x, input word_t y, input word_t z);
    vec3_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    point_q.push_back(p);
  endtask

  function automatic word_t random_extreme();
    case ($urandom_range(0, 4))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      default: return ROT_W_RESET;
    endcase
  endfunction

  function automatic word_t random_coord();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel <= 8) return word_t'($urandom) >>> 8;       // about +-128.0
    if (sel <= 11) return word_t'($urandom);
    if (sel == 12) return random_extreme();
    return word_t'($urandom) >>> 14;                     // about +-2.0
  endfunction

  function automatic word_t random_part(input int qmode);
    case (qmode)
      0: return word_t'($urandom) >>> 2;
      1: return word_t'($urandom);
      2: return ($urandom_range(0, 1) == 0) ? random_extreme() : word_t'($urandom) >>> 1;
      default: return word_t'($urandom) >>> 8;
    endcase
  endfunction

  function automatic word_t random_pivot();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return random_extreme();
      default: return word_t'($urandom) >>> 8;
    endcase
  endfunction

  initial begin
    int qmode;
    word_t w;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // identity rotation out of reset
    add_point('0, '0, '0);
    add_point(WORD_MAX, WORD_MAX, WORD_MAX);
    add_point(WORD_MIN, WORD_MIN, WORD_MIN);
    add_point(WORD_MAX, WORD_MIN, 32'sd1);
    add_point(-32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa);
    add_point(32'sh0001_0000, -32'sh0001_0000, 32'sh7fff_0000);

    // 90 degrees about z around an offset pivot
    reconfigure(32'sd759250125, '0, '0, 32'sd759250125,
                32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
    add_point(32'sh0005_0000, '0, '0);
    add_point(WORD_MIN, WORD_MAX, '0);

    // most negative i part: conjugate must not overflow
    reconfigure('0, WORD_MIN, '0, '0, '0, '0, '0);
    add_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    add_point(WORD_MAX, 32'sd1, -32'sd1);
    add_point(WORD_MIN, WORD_MIN, WORD_MIN);

    // saturation everywhere
    reconfigure(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN);
    add_point(WORD_MAX, WORD_MAX, WORD_MAX);
    add_point(WORD_MIN, '0, WORD_MAX);
    add_point('0, '0, '0);
    reconfigure(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
    add_point(WORD_MIN, WORD_MIN, WORD_MIN);
    add_point(WORD_MAX, 32'sd1, WORD_MIN);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      qmode = ph % 4;
      // near-identity mode keeps w close to one
      w = (qmode == 3) ? ROT_W_RESET - (word_t'($urandom) >>> 8) : random_part(qmode);
      reconfigure(w, random_part(qmode), random_part(qmode), random_part(qmode),
                  random_pivot(), random_pivot(), random_pivot());
      for (int i = 0; i < PHASE_POINTS; i++)
        add_point(random_coord(), random_coord(), random_coord());
    end

    wait_idle();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("%0t: timeout, %0d requests queued, %0d results outstanding",
             $time, point_q.size(), rotated_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
design/qpr_pkg.sv
design/qpr_addsat.sv
design/qpr_mul_bank.sv
design/qpr_combine.sv
design/quaternion_point_rotator.sv
tb/tb_top.sv
